// ===== hdl/ael_pkg.sv =====
package ael_pkg;

	// field and register widths
	localparam int GAIN_W    = 10;
	localparam int LINES_W   = 16;
	localparam int SHS_W     = 10;
	localparam int MINEXP_W  = 10;
	localparam int MEAN_W    = 16;
	localparam int ROM_W     = 24;
	localparam int FAC_W     = 15;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 16;

	// iterative unit sizes
	localparam int DIV_N_W  = 56;
	localparam int DIV_D_W  = 30;
	localparam int SQ_W     = 40;
	localparam int SQ_STEPS = 20;
	localparam int CNT_W    = 6;

	localparam int unsigned GAIN_MAX_DEF = 720;
	localparam int unsigned GAIN_MIN_DEF = 0;

	// factor limits, U1.14
	localparam logic [FAC_W-1:0] FAC_ONE = 15'd16384;
	localparam logic [FAC_W-1:0] FAC_LO  = 15'd10928;
	localparam logic [FAC_W-1:0] FAC_HI  = 15'd24576;

	// gain table construction, products kept in units of 1e-9
	localparam logic [127:0] E9 = 128'd1000000000;
	localparam logic [39:0] POW_BITS [GAIN_W] = '{
		40'd1011579454, 40'd1023292992, 40'd1047128548, 40'd1096478196,
		40'd1202264435, 40'd1445439771, 40'd2089296131, 40'd4365158322,
		40'd19054607180, 40'd363078054770
	};

	typedef enum logic [4:0] {
		OP_NONE,
		OP_ACCEPT,
		OP_DIV_STEP,
		OP_AVG_SET,
		OP_RATIO,
		OP_SQ_START,
		OP_SQ_STEP,
		OP_FACTOR,
		OP_MUL1,
		OP_MUL2,
		OP_TEST,
		OP_R_SET,
		OP_RSQ,
		OP_PROBE,
		OP_RD1,
		OP_RD2,
		OP_CMP,
		OP_FINISH
	} op_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic last;
		logic over;
		logic srch_done;
		logic out_free;
	} status_t;

	// entry g = round(4096 * product of 10^(2^k/200) for set bits k), saturated
	function automatic logic [ROM_W-1:0] gain_entry(input logic [GAIN_W-1:0] g);
		logic [127:0] p;
		logic [127:0] v;
		int k;
		p = E9;
		for (k = 0; k < GAIN_W; k++) begin
			if (g[k]) begin
				p = (p * 128'(POW_BITS[k]) + E9 / 2) / E9;
			end
		end
		v = (p * 128'd4096 + E9 / 2) / E9;
		return (v > 128'hFFFFFF) ? 24'hFFFFFF : v[ROM_W-1:0];
	endfunction

endpackage

// ===== hdl/ael_ctrl.sv =====
module ael_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             frame_valid,
	output logic             frame_stall,
	input  ael_pkg::status_t st,
	output ael_pkg::cmd_t    cmd
);
	import ael_pkg::*;

	typedef enum logic [17:0] {
		S_IDLE     = 18'h00001,
		S_AVG_SET  = 18'h00002,
		S_RATIO    = 18'h00004,
		S_Q_DIV    = 18'h00008,
		S_SQ_START = 18'h00010,
		S_SQ       = 18'h00020,
		S_FACTOR   = 18'h00040,
		S_MUL1     = 18'h00080,
		S_MUL2     = 18'h00100,
		S_TEST     = 18'h00200,
		S_R_DIV    = 18'h00400,
		S_R_SET    = 18'h00800,
		S_RSQ      = 18'h01000,
		S_PROBE    = 18'h02000,
		S_RD1      = 18'h04000,
		S_RD2      = 18'h08000,
		S_CMP      = 18'h10000,
		S_FINISH   = 18'h20000
	} state_t;

	state_t state_q, state_d;

	assign frame_stall = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd.op  = OP_NONE;
		case (state_q)
			S_IDLE: begin
				if (frame_valid) begin
					cmd.op  = OP_ACCEPT;
					state_d = S_AVG_SET;
				end
			end
			S_AVG_SET: begin
				cmd.op  = OP_AVG_SET;
				state_d = S_RATIO;
			end
			S_RATIO: begin
				cmd.op  = OP_RATIO;
				state_d = S_Q_DIV;
			end
			S_Q_DIV: begin
				cmd.op = OP_DIV_STEP;
				if (st.last) state_d = S_SQ_START;
			end
			S_SQ_START: begin
				cmd.op  = OP_SQ_START;
				state_d = S_SQ;
			end
			S_SQ: begin
				cmd.op = OP_SQ_STEP;
				if (st.last) state_d = S_FACTOR;
			end
			S_FACTOR: begin
				cmd.op  = OP_FACTOR;
				state_d = S_MUL1;
			end
			S_MUL1: begin
				cmd.op  = OP_MUL1;
				state_d = S_MUL2;
			end
			S_MUL2: begin
				cmd.op  = OP_MUL2;
				state_d = S_TEST;
			end
			S_TEST: begin
				cmd.op  = OP_TEST;
				state_d = st.over ? S_R_DIV : S_FINISH;
			end
			S_R_DIV: begin
				cmd.op = OP_DIV_STEP;
				if (st.last) state_d = S_R_SET;
			end
			S_R_SET: begin
				cmd.op  = OP_R_SET;
				state_d = S_RSQ;
			end
			S_RSQ: begin
				cmd.op  = OP_RSQ;
				state_d = S_PROBE;
			end
			S_PROBE: begin
				if (st.srch_done) begin
					state_d = S_FINISH;
				end else begin
					cmd.op  = OP_PROBE;
					state_d = S_RD1;
				end
			end
			S_RD1: begin
				cmd.op  = OP_RD1;
				state_d = S_RD2;
			end
			S_RD2: begin
				cmd.op  = OP_RD2;
				state_d = S_CMP;
			end
			S_CMP: begin
				cmd.op  = OP_CMP;
				state_d = S_PROBE;
			end
			S_FINISH: begin
				if (st.out_free) begin
					cmd.op  = OP_FINISH;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

`ifndef SYNTH
	a_finish_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FINISH && !st.out_free) |=> state_q == S_FINISH)
		else $error("finish left while result register busy");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && frame_valid) |=> state_q == S_AVG_SET)
		else $error("accepted item did not start averaging");
`endif

endmodule

// ===== hdl/ael_dp.sv =====
module ael_dp #(
	parameter int unsigned GAIN_MAX = ael_pkg::GAIN_MAX_DEF,
	parameter int unsigned GAIN_MIN = ael_pkg::GAIN_MIN_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [ael_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ael_pkg::CFG_DAT_W-1:0]   cfg_data,
	input  logic [ael_pkg::MEAN_W-1:0]      frame_mean,
	input  ael_pkg::cmd_t                   cmd,
	output ael_pkg::status_t                st,
	input  logic                            result_stall,
	output logic                            result_valid,
	output logic [ael_pkg::LINES_W-1:0]     exposure_lines,
	output logic [ael_pkg::GAIN_W-1:0]      gain_code,
	output logic                            on_target,
	output logic                            gain_capped
);
	import ael_pkg::*;

	localparam int ADDR_W = $clog2(GAIN_MAX + 1);

	// divide by 5 as multiply by ceil(2^21/5), exact for sums below 2^21/3
	localparam logic [19:0] DIV5_RECIP = 20'd419431;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_LINES = 3'd0,
		REG_SHUTTER_OFF = 3'd1,
		REG_MIN_EXP     = 3'd2,
		REG_TARGET      = 3'd3,
		REG_GAIN_CAP    = 3'd4
	} reg_idx_t;

	// configuration
	logic [LINES_W-1:0]  frame_lines_q;
	logic [SHS_W-1:0]    shutter_off_q;
	logic [MINEXP_W-1:0] min_exp_q;
	logic [MEAN_W-1:0]   target_q;
	logic [GAIN_W-1:0]   gain_cap_q;

	// loop state
	logic [LINES_W-1:0] expo_now_q;
	logic [GAIN_W-1:0]  gain_now_q;
	logic [MEAN_W-1:0]  avg_q;

	// working registers
	logic [DIV_D_W-1:0] div_rem_q, div_den_q;
	logic [DIV_N_W-1:0] div_quo_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [SQ_W-1:0]    sq_x_q, sq_root_q, sq_bit_q;
	logic               on_q;
	logic [FAC_W-1:0]   fac_q;
	logic [30:0]        m1_q;
	logic [54:0]        b_q;
	logic [LINES_W-1:0] expo_q;
	logic [ROM_W-1:0]   r_q;
	logic [47:0]        rsq_q, prod_q;
	logic [ROM_W-1:0]   ta_q, rom_q;
	logic [ADDR_W-1:0]  lo_q, hi_q, mid_q;

	// result register
	logic               res_valid_q;
	logic [LINES_W-1:0] res_expo_q;
	logic [GAIN_W-1:0]  res_gain_q;
	logic               res_on_q, res_capped_q;

	// gain rom
	logic [ROM_W-1:0] gain_rom [GAIN_MAX+1];
	for (genvar g = 0; g <= GAIN_MAX; g++) begin : g_rom
		assign gain_rom[g] = gain_entry(GAIN_W'(g));
	end

	logic [ADDR_W-1:0] rom_addr;
	logic              rom_rd;
	logic [ADDR_W-1:0] gi;
	logic [ADDR_W:0]   mid_sum;
	logic [ADDR_W-1:0] mid;

	logic [16:0]         ceil_l;
	logic [LINES_W-1:0]  mn, top;
	logic [GAIN_W-1:0]   cap_eff;
	logic [MEAN_W-1:0]   d;
	logic [23:0]         t100, d90, d111;
	logic [18:0]         avg_num;
	logic [39:0]         avg_prod;
	logic [DIV_D_W:0]    div_sh;
	logic                div_ge;
	logic [SQ_W-1:0]     sq_sum;
	logic [55:0]         top_sh26, mn_sh26, e_low, e_rnd;
	logic [GAIN_W-1:0]   need, code_lo;
	logic                capped;

	assign cfg_ready = 1'b1;

	// derived limits
	assign mn      = (min_exp_q == '0) ? 16'd1 : {6'd0, min_exp_q};
	assign ceil_l  = {1'b0, frame_lines_q} - {7'd0, shutter_off_q};
	assign top     = (ceil_l[16] || (ceil_l[15:0] < mn)) ? mn : ceil_l[15:0];
	assign cap_eff = (gain_cap_q < GAIN_W'(GAIN_MIN)) ? GAIN_W'(GAIN_MIN) :
	                 (gain_cap_q > GAIN_W'(GAIN_MAX)) ? GAIN_W'(GAIN_MAX) : gain_cap_q;
	assign d       = (avg_q < 16'd64) ? 16'd64 : avg_q;
	assign t100    = 24'(target_q) * 24'd100;
	assign d90     = 24'(d) * 24'd90;
	assign d111    = 24'(d) * 24'd111;
	assign avg_num = 19'({avg_q, 1'b0}) + 19'(avg_q) + 19'({frame_mean, 1'b0}) + 19'd2;
	assign avg_prod = 40'(div_quo_q[18:0]) * 40'(DIV5_RECIP);

	assign top_sh26 = {14'd0, top, 26'd0};
	assign mn_sh26  = {14'd0, mn, 26'd0};
	assign e_low    = ({1'b0, b_q} < mn_sh26) ? mn_sh26 : {1'b0, b_q};
	assign e_rnd    = e_low + 56'(33554432);

	assign gi = (gain_now_q > GAIN_W'(GAIN_MAX)) ? ADDR_W'(GAIN_MAX) : gain_now_q[ADDR_W-1:0];
	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q} + (ADDR_W+1)'(1);
	assign mid     = mid_sum[ADDR_W:1];

	assign div_sh = {div_rem_q, div_quo_q[DIV_N_W-1]};
	assign div_ge = (div_sh >= {1'b0, div_den_q});
	assign sq_sum = sq_root_q + sq_bit_q;

	assign need    = GAIN_W'(lo_q);
	assign code_lo = (need < GAIN_W'(GAIN_MIN)) ? GAIN_W'(GAIN_MIN) : need;
	assign capped  = (code_lo > cap_eff);

	assign st.last      = (cnt_q == '0);
	assign st.over      = ({1'b0, b_q} > top_sh26);
	assign st.srch_done = (lo_q == hi_q);
	assign st.out_free  = !res_valid_q || !result_stall;

	always_comb begin
		rom_rd   = 1'b0;
		rom_addr = gi;
		case (cmd.op)
			OP_ACCEPT: begin
				rom_rd   = 1'b1;
				rom_addr = gi;
			end
			OP_PROBE: begin
				rom_rd   = 1'b1;
				rom_addr = mid - ADDR_W'(1);
			end
			OP_RD1: begin
				rom_rd   = 1'b1;
				rom_addr = mid_q;
			end
			default: begin
				rom_rd = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (rom_rd) rom_q <= gain_rom[rom_addr];
	end

	// configuration, loop state, search bounds and result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_lines_q <= 16'd1125;
			shutter_off_q <= 10'd8;
			min_exp_q     <= 10'd1;
			target_q      <= 16'd32768;
			gain_cap_q    <= 10'd300;
			expo_now_q    <= 16'd725;
			gain_now_q    <= '0;
			avg_q         <= 16'd32768;
			lo_q          <= '0;
			hi_q          <= '0;
			res_valid_q   <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					REG_FRAME_LINES: frame_lines_q <= cfg_data;
					REG_SHUTTER_OFF: shutter_off_q <= cfg_data[SHS_W-1:0];
					REG_MIN_EXP:     min_exp_q     <= cfg_data[MINEXP_W-1:0];
					REG_TARGET:      target_q      <= cfg_data;
					REG_GAIN_CAP:    gain_cap_q    <= cfg_data[GAIN_W-1:0];
					default: ;
				endcase
			end
			if (cmd.op == OP_FINISH) res_valid_q <= 1'b1;
			else if (res_valid_q && !result_stall) res_valid_q <= 1'b0;
			case (cmd.op)
				OP_AVG_SET: avg_q <= avg_prod[36:21];
				OP_TEST: begin
					lo_q <= '0;
					hi_q <= ADDR_W'(GAIN_MAX);
				end
				OP_CMP: begin
					if (rsq_q >= prod_q) lo_q <= mid_q;
					else hi_q <= mid_q - ADDR_W'(1);
				end
				OP_FINISH: begin
					expo_now_q  <= expo_q;
					gain_now_q  <= capped ? cap_eff : code_lo;
				end
				default: ;
			endcase
		end
	end

	// datapath payload
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_ACCEPT: begin
				div_quo_q <= DIV_N_W'(avg_num);
			end
			OP_DIV_STEP: begin
				if (div_ge) begin
					div_rem_q <= DIV_D_W'(div_sh - {1'b0, div_den_q});
				end else begin
					div_rem_q <= div_sh[DIV_D_W-1:0];
				end
				div_quo_q <= {div_quo_q[DIV_N_W-2:0], div_ge};
				cnt_q     <= cnt_q - CNT_W'(1);
			end
			OP_RATIO: begin
				on_q      <= (t100 > d90) && (t100 < d111);
				div_rem_q <= '0;
				div_quo_q <= DIV_N_W'({target_q, 28'd0});
				div_den_q <= DIV_D_W'(d);
				cnt_q     <= CNT_W'(DIV_N_W - 1);
			end
			OP_SQ_START: begin
				sq_x_q    <= div_quo_q[SQ_W-1:0];
				sq_root_q <= '0;
				sq_bit_q  <= SQ_W'(1) << (SQ_W - 2);
				cnt_q     <= CNT_W'(SQ_STEPS - 1);
			end
			OP_SQ_STEP: begin
				if (sq_x_q >= sq_sum) begin
					sq_x_q    <= sq_x_q - sq_sum;
					sq_root_q <= (sq_root_q >> 1) + sq_bit_q;
				end else begin
					sq_root_q <= sq_root_q >> 1;
				end
				sq_bit_q <= sq_bit_q >> 2;
				cnt_q    <= cnt_q - CNT_W'(1);
			end
			OP_FACTOR: begin
				if (on_q) fac_q <= FAC_ONE;
				else if (sq_root_q > SQ_W'(FAC_HI)) fac_q <= FAC_HI;
				else if (sq_root_q < SQ_W'(FAC_LO)) fac_q <= FAC_LO;
				else fac_q <= sq_root_q[FAC_W-1:0];
			end
			OP_MUL1: m1_q <= 31'(expo_now_q) * 31'(fac_q);
			OP_MUL2: b_q  <= 55'(m1_q) * 55'(rom_q);
			OP_TEST: begin
				expo_q    <= st.over ? top : e_rnd[41:26];
				div_rem_q <= '0;
				div_quo_q <= {1'b0, b_q} + {27'd0, top, 13'd0};
				div_den_q <= {top, 14'd0};
				cnt_q     <= CNT_W'(DIV_N_W - 1);
			end
			OP_R_SET: r_q <= (|div_quo_q[DIV_N_W-1:ROM_W]) ? {ROM_W{1'b1}} :
			                 div_quo_q[ROM_W-1:0];
			OP_RSQ:   rsq_q <= 48'(r_q) * 48'(r_q);
			OP_PROBE: mid_q <= mid;
			OP_RD1:   ta_q  <= rom_q;
			OP_RD2:   prod_q <= 48'(ta_q) * 48'(rom_q);
			OP_FINISH: begin
				res_expo_q   <= expo_q;
				res_gain_q   <= capped ? cap_eff : code_lo;
				res_on_q     <= on_q;
				res_capped_q <= capped;
			end
			default: ;
		endcase
	end

	assign result_valid   = res_valid_q;
	assign exposure_lines = res_expo_q;
	assign gain_code      = res_gain_q;
	assign on_target      = res_on_q;
	assign gain_capped    = res_capped_q;

`ifndef SYNTH
	a_bounds: assert property (@(posedge clk) disable iff (!arst_n) lo_q <= hi_q)
		else $error("search bounds crossed");

	a_capped_at_cap: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_capped_q) |-> res_gain_q == cap_eff)
		else $error("capped gain differs from cap");

	a_expo_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> res_expo_q != '0)
		else $error("zero exposure delivered");
`endif

endmodule

// ===== hdl/auto_exposure_ladder_top.sv =====
// auto exposure for a sensor at fixed frame rate: give it one frame mean (U10.6) per
// frame and it returns one item with the next exposure in lines, the analog gain code in
// 0.1 dB steps, a flag for brightness inside the hold band and a flag for gain held at the
// cap. The mean is averaged 0.6/0.4 with history, a square-root correction is applied and
// the result is spent on exposure first, up to frame_lines less the shutter offset, then
// on gain.
// Most of an item's work goes to a shared 56-step restoring divider (run once, or twice
// when gain is needed), a 20-step square root and, when gain is needed, a binary search
// of the gain rom, each probe passing through the states PROBE, RD1, RD2 and CMP; the
// average itself is a single reciprocal multiply. The final step waits as long as the
// previous result is still stalled. Frame input stalls while an item is in work; a
// finished result waits in an output register and the next frame is taken meanwhile.
// Configuration may be written whenever the block is idle, cfg_ready is always high.
module auto_exposure_ladder_top #(
	parameter int unsigned GAIN_MAX = ael_pkg::GAIN_MAX_DEF,
	parameter int unsigned GAIN_MIN = ael_pkg::GAIN_MIN_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration writes
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [ael_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ael_pkg::CFG_DAT_W-1:0] cfg_data,
	// frame mean item
	input  logic                          frame_valid,
	output logic                          frame_stall,
	input  logic [ael_pkg::MEAN_W-1:0]    frame_mean,
	// result item
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic [ael_pkg::LINES_W-1:0]   exposure_lines,
	output logic [ael_pkg::GAIN_W-1:0]    gain_code,
	output logic                          on_target,
	output logic                          gain_capped
);
	import ael_pkg::*;

	cmd_t    cmd;
	status_t st;

	// sequencer: one state per step of the update
	ael_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.frame_valid (frame_valid),
		.frame_stall (frame_stall),
		.st          (st),
		.cmd         (cmd)
	);

	// registers, divider, square root, multipliers, gain rom and result register
	ael_dp #(
		.GAIN_MAX (GAIN_MAX),
		.GAIN_MIN (GAIN_MIN)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.frame_mean     (frame_mean),
		.cmd            (cmd),
		.st             (st),
		.result_stall   (result_stall),
		.result_valid   (result_valid),
		.exposure_lines (exposure_lines),
		.gain_code      (gain_code),
		.on_target      (on_target),
		.gain_capped    (gain_capped)
	);

endmodule
